// File: hw/rtl/gmc_pkg.sv
// shared types, sizes and codes of the gf2 matrix equation combiner
package gmc_pkg;

	localparam int ROWS               = 8;
	localparam int EQUATIONS          = 256;
	localparam int WORDS_PER_EQUATION = 512;
	localparam int WORD_BITS          = 64;

	localparam int BLOCKS    = (EQUATIONS + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BLK_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int POS_W     = $clog2(WORD_BITS);
	localparam int WADDR_W   = (WORDS_PER_EQUATION > 1) ? $clog2(WORDS_PER_EQUATION) : 1;

	localparam int ACTION_W = 2;
	localparam int ROW_W    = 3;
	localparam int BLOCK_W  = 2;
	localparam int EQ_W     = 8;
	localparam int WI_W     = 9;
	localparam int DATA_W   = 64;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ACC   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ROW_W-1:0]    row;
		logic [BLOCK_W-1:0]  block;
		logic [EQ_W-1:0]     equation;
		logic [WI_W-1:0]     word_index;
		logic [DATA_W-1:0]   data;
	} gmc_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] result_word;
		logic [ROW_W-1:0]  out_row;
		logic [WI_W-1:0]   out_word;
	} gmc_out_t;

	typedef struct packed {
		logic [ACTION_W-1:0]  action;
		logic [ROW_W-1:0]     row;
		logic [WI_W-1:0]      word_index;
		logic [WORD_BITS-1:0] data;
		logic [ROWS-1:0]      mask;
		logic                 zero;
	} gmc_op_t;

endpackage

// File: hw/rtl/gmc_front.sv
// front part: accepts items, holds the coefficient store, classifies and builds row masks
module gmc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  gmc_pkg::gmc_in_t req,
	output logic            op_valid,
	input  logic            op_ready,
	output gmc_pkg::gmc_op_t op
);
	import gmc_pkg::*;

	logic                 s1_valid_q;
	gmc_in_t              item_s1;
	logic [WORD_BITS-1:0] coef_s1 [ROWS];
	logic                 accept;
	logic                 take;
	logic                 load_ok;
	logic                 wi_ok;
	logic                 eq_ok;
	logic [BLK_W-1:0]     rd_blk;
	logic [POS_W-1:0]     pos_s1;

	assign req_ready = !s1_valid_q || op_ready;
	assign accept    = req_valid && req_ready;
	assign wi_ok     = int'(req.word_index) < WORDS_PER_EQUATION;
	assign eq_ok     = int'(req.equation) < EQUATIONS;
	assign load_ok   = (int'(req.row) < ROWS) && (int'(req.block) < BLOCKS);
	assign rd_blk    = BLK_W'(req.equation >> POS_W);

	always_comb begin
		take = 1'b0;
		case (req.action)
			ACT_ACC:   take = eq_ok && wi_ok;
			ACT_CLEAR: take = wi_ok;
			ACT_READ:  take = 1'b1;
			default:   take = 1'b0;
		endcase
	end

	// coefficient store, one bank per row
	for (genvar r = 0; r < ROWS; r++) begin : g_coef
		logic [WORD_BITS-1:0] mem [BLOCKS];
		always_ff @(posedge clk) begin
			if (accept && req.action == ACT_LOAD && load_ok &&
			    req.row[ROW_IDX_W-1:0] == ROW_IDX_W'(r)) begin
				mem[req.block[BLK_W-1:0]] <= req.data[WORD_BITS-1:0];
			end
			if (accept && req.action == ACT_ACC) begin
				coef_s1[r] <= mem[rd_blk];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= take;
		end else if (op_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

	assign pos_s1   = item_s1.equation[POS_W-1:0];
	assign op_valid = s1_valid_q;

	always_comb begin
		op.action     = item_s1.action;
		op.row        = item_s1.row;
		op.word_index = item_s1.word_index;
		op.data       = item_s1.data[WORD_BITS-1:0];
		op.zero       = !((int'(item_s1.row) < ROWS) &&
		                  (int'(item_s1.word_index) < WORDS_PER_EQUATION));
		for (int r = 0; r < ROWS; r++) begin
			op.mask[r] = coef_s1[r][pos_s1];
		end
	end

endmodule

// File: hw/rtl/gmc_queue.sv
// short queue of classified operations between front and back
module gmc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  gmc_pkg::gmc_op_t push_op,
	output logic             pop_valid,
	input  logic             pop_ready,
	output gmc_pkg::gmc_op_t pop_op
);
	import gmc_pkg::*;

	gmc_op_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = int'(count_q) < QDEPTH;
	assign pop_valid  = count_q != '0;
	assign pop_op     = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/gmc_back.sv
// back part: banked accumulator store, read-modify-write sequencer and result register
module gmc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  gmc_pkg::gmc_op_t  op,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output gmc_pkg::gmc_out_t rsp
);
	import gmc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                 state_q;
	gmc_op_t              op_q;
	logic                 rsp_valid_q;
	gmc_out_t             rsp_q;
	logic [WORD_BITS-1:0] rdata [ROWS];
	logic                 rd_en;
	logic                 clr_now;
	logic                 acc_now;
	logic                 rd_done;
	logic [WADDR_W-1:0]   waddr;
	logic [WADDR_W-1:0]   raddr;

	assign op_ready = state_q == ST_IDLE;
	assign clr_now  = op_ready && op_valid && op.action == ACT_CLEAR;
	assign rd_en    = op_ready && op_valid && op.action != ACT_CLEAR;
	assign acc_now  = state_q == ST_EXEC && op_q.action == ACT_ACC;
	assign rd_done  = !rsp_valid_q || rsp_ready;
	assign raddr    = op.word_index[WADDR_W-1:0];
	assign waddr    = clr_now ? op.word_index[WADDR_W-1:0] : op_q.word_index[WADDR_W-1:0];

	// one accumulator bank per row
	for (genvar r = 0; r < ROWS; r++) begin : g_acc
		logic [WORD_BITS-1:0] mem [WORDS_PER_EQUATION];
		always_ff @(posedge clk) begin
			if (clr_now) begin
				mem[waddr] <= '0;
			end else if (acc_now && op_q.mask[r]) begin
				mem[waddr] <= rdata[r] ^ op_q.data;
			end
			if (rd_en) begin
				rdata[r] <= mem[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			op_q <= op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rd_en) begin
						state_q <= ST_EXEC;
					end
					if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (op_q.action == ACT_READ) begin
						if (rd_done) begin
							rsp_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
						if (rsp_ready) begin
							rsp_valid_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && op_q.action == ACT_READ && rd_done) begin
			rsp_q.result_word <= op_q.zero ? '0 : DATA_W'(rdata[op_q.row[ROW_IDX_W-1:0]]);
			rsp_q.out_row     <= op_q.row;
			rsp_q.out_word    <= op_q.word_index;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hw/rtl/gf2_matrix_equation_combiner.sv
// top level of the gf2 matrix equation combiner: front, queue and back
//
// channel   direction  payload    handshake
// req       in         gmc_in_t   req_valid / req_ready
// rsp       out        gmc_out_t  rsp_valid / rsp_ready
//
// front takes one item a cycle while the two-entry queue has room; loads finish there
// back: clear is done in idle; accumulate and read pass idle (bank read), then exec (write or result)
// back speed is set by the single read and write port of each accumulator bank
// reset clears control only; coefficient and accumulator stores hold garbage until written
// a stalled result holds the back once a further read reaches exec, which fills the queue and then drops req_ready
module gf2_matrix_equation_combiner (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  gmc_pkg::gmc_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output gmc_pkg::gmc_out_t rsp
);
	import gmc_pkg::*;

	logic    f_valid;
	logic    f_ready;
	gmc_op_t f_op;
	logic    b_valid;
	logic    b_ready;
	gmc_op_t b_op;

	gmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.op_valid  (f_valid),
		.op_ready  (f_ready),
		.op        (f_op)
	);

	gmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_op    (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_op     (b_op)
	);

	gmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (b_valid),
		.op_ready  (b_ready),
		.op        (b_op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
